[hw/rtl/bit_matrix_transpose_top_defines.svh]
// assertion helpers for the transpose block
`ifndef BIT_MATRIX_TRANSPOSE_TOP_DEFINES_SVH
`define BIT_MATRIX_TRANSPOSE_TOP_DEFINES_SVH

// same-cycle implication
`define BMT_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define BMT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// delayed implication, consequent checked after the antecedent
`define BMT_ASSERT_AFTER2(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

[hw/rtl/bmt_pkg.sv]
package bmt_pkg;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT = 64;

   localparam int LINE_W    = 6;
   localparam int GROUP_W   = 3;
   localparam int BYTE_W    = 8;
   localparam int BANKS     = 8;
   localparam int CFG_W     = 7;
   localparam int CFG_IDX_W = 1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
   localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
   localparam logic [CFG_W-1:0] SIZE_MASK = 7'h78;

   typedef struct packed {
      logic               kind;
      logic [LINE_W-1:0]  line;
      logic [GROUP_W-1:0] group;
      logic [BYTE_W-1:0]  in_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              range_error;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic load;
   } cmd_type;

endpackage

[hw/rtl/bmt_ram.sv]
module bmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bmt_ctrl.sv]
module bmt_ctrl import bmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // hold off during the ram read cycle and while the result is blocked
   assign req_stall  = (state_ff == ST_READ) || (rsp_valid_ff && rsp_stall);
   assign cmd.accept = req_valid && !req_stall;
   assign cmd.load   = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/bmt_datapath.sv]
module bmt_datapath import bmt_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output rsp_type              rsp_data
);

   localparam int BYTES_PER_ROW = MAX_COLS / 8;
   localparam int ROW_BLOCKS    = (MAX_ROWS + 7) / 8;
   localparam int BANK_DEPTH    = ROW_BLOCKS * BYTES_PER_ROW;
   localparam int BANK_AW       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int ROW_W         = LINE_W + 1;

   typedef logic [7:0][2:0] grp_tab_type;

   // a byte group past the row width spills into following rows
   function automatic grp_tab_type make_quot_tab();
      grp_tab_type t;
      for (int c = 0; c < 8; c++) begin
         t[c] = 3'(c / BYTES_PER_ROW);
      end
      return t;
   endfunction

   function automatic grp_tab_type make_rem_tab();
      grp_tab_type t;
      for (int c = 0; c < 8; c++) begin
         t[c] = 3'(c % BYTES_PER_ROW);
      end
      return t;
   endfunction

   localparam grp_tab_type QUOT_TAB = make_quot_tab();
   localparam grp_tab_type REM_TAB  = make_rem_tab();

   function automatic logic [BANK_AW-1:0] bank_addr(input logic [ROW_W-1:0] row,
                                                     input logic [2:0] col);
      int a;
      a = int'(row >> 3) * BYTES_PER_ROW + int'(col);
      return a[BANK_AW-1:0];
   endfunction

   function automatic logic row_ok(input logic [ROW_W-1:0] row);
      return int'(row) < MAX_ROWS;
   endfunction

   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r, input int max_v);
      logic [CFG_W-1:0] m;
      m = r & SIZE_MASK;
      return (int'(m) > max_v) ? CFG_W'(max_v) : m;
   endfunction

   logic [CFG_W-1:0] row_count_ff, col_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_RESET;
         col_count_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_ROW_COUNT: row_count_ff <= csr_wdata;
            CFG_COL_COUNT: col_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [CFG_W-1:0]   rows_eff, cols_eff, line_ext, group8;
   logic               is_read, err_w, err_r, err;
   logic [2:0]         c_sel, q_sel, r_sel;
   logic [ROW_W-1:0]   wr_row;
   logic               wr_en;
   logic [BANK_AW-1:0] wr_addr;
   logic [BANKS-1:0]   mask;
   logic [BYTE_W-1:0]  rd_data [BANKS];

   assign rows_eff = eff_size(row_count_ff, MAX_ROWS);
   assign cols_eff = eff_size(col_count_ff, MAX_COLS);
   assign line_ext = CFG_W'(req_data.line);
   assign group8   = CFG_W'({req_data.group, 3'b000});
   assign is_read  = (req_data.kind == KIND_READ);
   assign err_w    = (line_ext >= rows_eff) || (group8 >= cols_eff);
   assign err_r    = (line_ext >= cols_eff) || (group8 >= rows_eff);
   assign err      = is_read ? err_r : err_w;

   assign c_sel = is_read ? req_data.line[5:3] : req_data.group;
   assign q_sel = QUOT_TAB[c_sel];
   assign r_sel = REM_TAB[c_sel];

   assign wr_row  = ROW_W'(req_data.line) + ROW_W'(q_sel);
   assign wr_addr = bank_addr(wr_row, r_sel);
   assign wr_en   = cmd.accept && !is_read && !err_w && row_ok(wr_row);

   // one bank per row mod 8, so the eight rows of a group read at once
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [2:0]       j_b;
      logic [ROW_W-1:0] rd_row;

      assign j_b    = 3'(b) - q_sel;
      assign rd_row = ROW_W'(group8) + ROW_W'(j_b) + ROW_W'(q_sel);

      bmt_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (BANK_DEPTH),
         .AW    (BANK_AW)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (wr_row[2:0] == 3'(b))),
         .wr_addr (wr_addr),
         .wr_data (req_data.in_byte),
         .rd_addr (bank_addr(rd_row, r_sel)),
         .rd_data (rd_data[b])
      );
   end

   // rows past the store read as zero; writes and out of range requests answer zero too
   for (genvar j = 0; j < BANKS; j++) begin : g_mask
      logic [ROW_W-1:0] row_j;
      assign row_j   = ROW_W'(group8) + ROW_W'(j) + ROW_W'(q_sel);
      assign mask[j] = is_read && !err && row_ok(row_j);
   end

   logic [BANKS-1:0] mask_ff;
   logic [2:0]       shift_ff, bitsel_ff;
   logic             err_ff;
   logic [BYTE_W-1:0] bits;
   rsp_type          rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mask_ff   <= mask;
         shift_ff  <= q_sel;
         bitsel_ff <= req_data.line[2:0];
         err_ff    <= err;
      end
   end

   for (genvar j = 0; j < BANKS; j++) begin : g_bits
      logic [2:0] bank_j;
      assign bank_j  = 3'(j) + shift_ff;
      assign bits[j] = rd_data[bank_j][bitsel_ff] & mask_ff[j];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.out_byte    <= bits;
         rsp_ff.range_error <= err_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hw/rtl/bit_matrix_transpose_top.sv]
// bit matrix transpose store
// request channel (req_valid / req_stall / req_data): kind 0 writes in_byte at
//   input row line, byte group group; kind 1 reads the transposed byte whose
//   bit j is input row 8*group+j at input column line
// response channel (rsp_valid / rsp_stall / rsp_data): one transaction per
//   request; writes answer zero, out of range requests flag range_error
// csr port: csr_we with csr_index 0 sets row_count, 1 sets col_count; write
//   only while no transaction is in flight
// latency: the response is valid two cycles after the request is accepted
// throughput: one transaction every two cycles, set by the registered read of
//   the eight bank rams, which holds the request side during its read cycle
// stall: a stalled response holds in the output register; while it waits,
//   the request side stalls too until the response is taken
// reset: synchronous, clears the handshake state and sets both sizes to 64;
//   store contents stay undefined until written, no clearing pass
module bit_matrix_transpose_top
   import bmt_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request transactions
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response transactions
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // size registers
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

`include "bit_matrix_transpose_top_defines.svh"

   // accept and load strobes from the controller
   cmd_type cmd;

   bmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // size registers, range check, banked store and output register
   bmt_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // request side is held during the ram read cycle
   `BMT_ASSERT_NEXT(a_stall_after_accept, cmd.accept, req_stall, "no stall in read cycle")

   // every accepted request shows up as a response after the ram read and output register
   `BMT_ASSERT_AFTER2(a_rsp_after_accept, cmd.accept, rsp_valid, "response missing")

   // an out of range transaction never carries data
   `BMT_ASSERT_IMPLIES(a_err_zero, rsp_valid && rsp_data.range_error,
                       rsp_data.out_byte == '0, "range error with nonzero byte")

endmodule

[tb/sv/transpose_check.sv]
module transpose_check
   import bmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   localparam int ROW_LIMIT     = MAX_ROWS_DEFAULT;
   localparam int COL_LIMIT     = MAX_COLS_DEFAULT;
   localparam int BYTES_PER_ROW = COL_LIMIT / 8;
   localparam int STORE_BYTES   = ROW_LIMIT * BYTES_PER_ROW;

   logic [BYTE_W-1:0] store_img [STORE_BYTES];
   logic [CFG_W-1:0]  row_size_q = CFG_RESET;
   logic [CFG_W-1:0]  col_size_q = CFG_RESET;
   rsp_type           awaited_rsps [$];

   // low three bits dropped, clipped at the store size
   function automatic int usable_size(input logic [CFG_W-1:0] value, input int limit);
      int v;
      v = int'(value & SIZE_MASK);
      return (v > limit) ? limit : v;
   endfunction

   // applies one request to the store image and returns its response
   function automatic rsp_type predict_transpose(input req_type item);
      rsp_type result;
      int      rows;
      int      cols;
      int      row;
      result = '0;
      rows   = usable_size(row_size_q, ROW_LIMIT);
      cols   = usable_size(col_size_q, COL_LIMIT);
      if (item.kind == KIND_WRITE) begin
         result.range_error = (int'(item.line) >= rows) || (int'(item.group) * 8 >= cols);
         if (!result.range_error)
            store_img[int'(item.line) * BYTES_PER_ROW + int'(item.group)] = item.in_byte;
      end else begin
         result.range_error = (int'(item.line) >= cols) || (int'(item.group) * 8 >= rows);
         if (!result.range_error) begin
            for (int j = 0; j < 8; j++) begin
               row = int'(item.group) * 8 + j;
               result.out_byte[j] =
                  store_img[row * BYTES_PER_ROW + int'(item.line[5:3])][item.line[2:0]];
            end
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         row_size_q = CFG_RESET;
         col_size_q = CFG_RESET;
         foreach (store_img[i]) store_img[i] = '0;
         awaited_rsps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_ROW_COUNT: row_size_q = csr_wdata;
               CFG_COL_COUNT: col_size_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            awaited_rsps.push_back(predict_transpose(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               $error("response transaction with none outstanding: out_byte %02h range_error %0b",
                      rsp_data.out_byte, rsp_data.range_error);
               fail_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.range_error !== want.range_error) begin
                  $error("range_error mismatch: expected %0b, actual %0b",
                         want.range_error, rsp_data.range_error);
                  fail_count++;
               end
            end
         end
      end
      pending = awaited_rsps.size();
   end

endmodule

[tb/sv/tb.sv]
module tb;
   import bmt_pkg::*;

   localparam int BYTES_PER_ROW   = MAX_COLS_DEFAULT / 8;
   localparam int STORE_BYTES     = MAX_ROWS_DEFAULT * BYTES_PER_ROW;
   localparam int PHASES          = 7;
   localparam int PHASE_ITEMS     = 78;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 4;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = CFG_ROW_COUNT;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending;

   // idle rates in percent, changed between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long receiver hold-off: the main flow bumps the request count,
   // the receiver process does the counting
   int hold_off_requests = 0;
   int hold_off_seen     = 0;
   int hold_left         = 0;

   // which store bytes hold data, so that no read touches a blank entry
   bit written_map [STORE_BYTES];
   int rows_in_use = 64;
   int cols_in_use = 64;

   int quiet_cycles = 0;

   // settings walked through after the directed part
   logic [CFG_W-1:0] phase_rows [PHASES] = '{7'd8, 7'd127, 7'd7, 7'd64, 7'd29, 7'd64, 7'd40};
   logic [CFG_W-1:0] phase_cols [PHASES] = '{7'd8, 7'd127, 7'd64, 7'd5, 7'd43, 7'd16, 7'd127};

   bit_matrix_transpose_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   transpose_check u_transpose_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // receiver: random stall, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_off_seen != hold_off_requests) begin
         hold_off_seen = hold_off_requests;
         hold_left     = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(input logic kind, input int line, input int group,
                                        input int value);
      req_type item;
      item.kind    = kind;
      item.line    = line[LINE_W-1:0];
      item.group   = group[GROUP_W-1:0];
      item.in_byte = value[BYTE_W-1:0];
      return item;
   endfunction

   // size as the block sees it: low three bits dropped, clipped at 64
   function automatic int usable_size(input logic [CFG_W-1:0] value);
      int v;
      v = int'(value & SIZE_MASK);
      return (v > 64) ? 64 : v;
   endfunction

   // uniform half the time, else right at a size boundary
   function automatic int pick_line();
      int v;
      case ($urandom_range(7))
         0: v = rows_in_use - 1;
         1: v = rows_in_use;
         2: v = cols_in_use - 1;
         3: v = cols_in_use;
         default: v = $urandom_range(63);
      endcase
      if (v < 0) v = 0;
      if (v > 63) v = 63;
      return v;
   endfunction

   // one request transaction; called at a falling edge, returns at one
   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // keeps the written map up to date; an in-range read over a blank
   // entry is turned into a write instead
   task automatic send_tracked(input req_type item);
      bit ready;
      int j;
      ready = 1'b1;
      if (item.kind == KIND_READ && int'(item.line) < cols_in_use
          && int'(item.group) * 8 < rows_in_use) begin
         for (j = 0; j < 8; j++)
            if (!written_map[(int'(item.group) * 8 + j) * BYTES_PER_ROW + int'(item.line[5:3])])
               ready = 1'b0;
         if (!ready) item.kind = KIND_WRITE;
      end
      if (item.kind == KIND_WRITE && int'(item.line) < rows_in_use
          && int'(item.group) * 8 < cols_in_use)
         written_map[int'(item.line) * BYTES_PER_ROW + int'(item.group)] = 1'b1;
      send_req(item);
   endtask

   // lower valid and wait until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // both size registers, back to back, while the block is idle
   task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      csr_we    <= 1'b1;
      csr_index <= CFG_ROW_COUNT;
      csr_wdata <= rows;
      @(negedge clock);
      csr_index <= CFG_COL_COUNT;
      csr_wdata <= cols;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      rows_in_use = usable_size(rows);
      cols_in_use = usable_size(cols);
   endtask

   // random part of one setting: mostly tiles (eight rows of one column
   // byte written, then reads of its columns), the rest noise
   task automatic run_random(input int count);
      int n;
      int g;
      int c;
      int k;
      int reads;
      n = 0;
      while (n < count) begin
         if (rows_in_use != 0 && cols_in_use != 0 && $urandom_range(99) < 65) begin
            g = $urandom_range(rows_in_use / 8 - 1);
            c = $urandom_range(cols_in_use / 8 - 1);
            for (k = 0; k < 8; k++) begin
               send_tracked(make_req(KIND_WRITE, g * 8 + k, c, $urandom_range(255)));
               n++;
            end
            reads = $urandom_range(4, 1);
            for (k = 0; k < reads; k++) begin
               send_tracked(make_req(KIND_READ, c * 8 + $urandom_range(7), g,
                                     $urandom_range(255)));
               n++;
            end
         end else begin
            send_tracked(make_req(1'($urandom_range(1)), pick_line(), $urandom_range(7),
                                  $urandom_range(255)));
            n++;
         end
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] pattern [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h0F, 8'hF0};
      int k;
      int p;

      // hold reset, then release it
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: corner tile at row group 0, column byte 0
      for (k = 0; k < 8; k++)
         send_tracked(make_req(KIND_WRITE, k, 0, int'(pattern[k])));
      send_tracked(make_req(KIND_READ, 0, 0, int'(8'hFF)));
      send_tracked(make_req(KIND_READ, 3, 0, int'(8'h00)));
      send_tracked(make_req(KIND_READ, 7, 0, int'(8'h55)));
      // directed: far corner tile, last row group and last column byte
      for (k = 0; k < 8; k++)
         send_tracked(make_req(KIND_WRITE, 56 + k, 7, int'(~pattern[7 - k])));
      send_tracked(make_req(KIND_READ, 63, 7, int'(8'hAA)));
      send_tracked(make_req(KIND_READ, 56, 7, int'(8'h00)));
      drain();

      // receiver idles more first, then the sender, then neither
      for (p = 0; p < PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 74;
         end else if (p < 4) begin
            send_idle_pct = 74;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_sizes(phase_rows[p], phase_cols[p]);
         // long receiver hold-off so the block fills and backs up
         if (p == 4) hold_off_requests++;
         run_random(PHASE_ITEMS);
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
